/* sv/bpcm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcm_pkg: shared constants and types of the binned pair contact matrix
// Sizes of the count store, the position and divisor widths, action and
// status codes, and the command passed from the front end to the back end.
// ----------------------------------------------------------------------------
package bpcm_pkg;

	localparam int BINS         = 256;
	localparam int COUNT_BITS   = 32;
	localparam int BIN_BITS     = $clog2(BINS);
	localparam int ADDR_BITS    = 2 * BIN_BITS;
	localparam int MEM_DEPTH    = 2 ** ADDR_BITS;
	localparam int EXT_BITS     = BIN_BITS + 1;

	localparam int POS_BITS     = 31;
	localparam int KB_BITS      = 20;
	localparam int DIV_BITS     = 30;
	localparam int BASES_PER_KB = 1000;
	localparam int STEP_BITS    = $clog2(POS_BITS);

	localparam int ACT_BITS     = 2;
	localparam int ROW_BITS     = 8;
	localparam int CELL_BITS    = 32;
	localparam int EXT_OUT_BITS = 9;
	localparam int STATUS_BITS  = 2;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [ACT_BITS-1:0] ACT_ADD   = 2'd0;
	localparam logic [ACT_BITS-1:0] ACT_READ  = 2'd1;
	localparam logic [ACT_BITS-1:0] ACT_CLEAR = 2'd2;

	localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_SAME  = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;

	typedef enum logic [2:0] {
		OP_COUNT,
		OP_SAME,
		OP_DROP,
		OP_READ,
		OP_CLEAR,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [BIN_BITS-1:0] a_bin;
		logic [BIN_BITS-1:0] b_bin;
	} cmd_t;

endpackage
`default_nettype wire

/* sv/bpcm_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcm_if: channel interfaces of the binned pair contact matrix
// Item, result and configuration channels, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface bpcm_item_if;
	logic                           valid;
	logic                           ready;
	logic [bpcm_pkg::ACT_BITS-1:0]  action;
	logic [bpcm_pkg::POS_BITS-1:0]  first_position;
	logic [bpcm_pkg::POS_BITS-1:0]  second_position;
	logic [bpcm_pkg::ROW_BITS-1:0]  read_row;
	logic [bpcm_pkg::ROW_BITS-1:0]  read_column;

	modport source (output valid, action, first_position, second_position, read_row,
		read_column, input ready);
	modport sink (input valid, action, first_position, second_position, read_row,
		read_column, output ready);
endinterface

interface bpcm_result_if;
	logic                              valid;
	logic                              ready;
	logic [bpcm_pkg::CELL_BITS-1:0]    cell_count;
	logic [bpcm_pkg::EXT_OUT_BITS-1:0] bins_in_use;
	logic [bpcm_pkg::STATUS_BITS-1:0]  status;

	modport source (output valid, cell_count, bins_in_use, status, input ready);
	modport sink (input valid, cell_count, bins_in_use, status, output ready);
endinterface

interface bpcm_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [bpcm_pkg::KB_BITS-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

/* sv/bpcm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcm_front: item intake and bin classification
// Holds the bin width, runs two radix-2 dividers side by side to find the
// bins of a pair, and pushes a classified command to the queue.
// ----------------------------------------------------------------------------
module bpcm_front (
	input  logic           clk,
	input  logic           arst_n,
	bpcm_item_if.sink      item,
	bpcm_cfg_if.sink       cfg,
	input  logic           clearing,
	output logic           push_valid,
	input  logic           push_ready,
	output bpcm_pkg::cmd_t push_cmd
);
	import bpcm_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t         state_q;
	logic [DIV_BITS-1:0]  divisor_q;
	logic [STEP_BITS-1:0] step_q;
	logic [ACT_BITS-1:0]  action_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [ROW_BITS-1:0]  col_q;
	logic [POS_BITS-1:0]  rem_a_q;
	logic [POS_BITS-1:0]  quo_a_q;
	logic [POS_BITS-1:0]  rem_b_q;
	logic [POS_BITS-1:0]  quo_b_q;
	logic [KB_BITS-1:0]   kb_eff;
	logic [DIV_BITS-1:0]  divisor_next;
	logic                 accept;

	function automatic logic [2*POS_BITS-1:0] div_step(
		input logic [POS_BITS-1:0] rem,
		input logic [POS_BITS-1:0] quo,
		input logic [DIV_BITS-1:0] dv
	);
		logic [POS_BITS-1:0] trial;
		logic [POS_BITS-1:0] dvx;
		trial = {rem[POS_BITS-2:0], quo[POS_BITS-1]};
		dvx   = POS_BITS'(dv);
		if (trial >= dvx) begin
			return {trial - dvx, quo[POS_BITS-2:0], 1'b1};
		end else begin
			return {trial, quo[POS_BITS-2:0], 1'b0};
		end
	endfunction

	assign cfg.ready    = 1'b1;
	assign item.ready   = (state_q == F_IDLE) && !clearing;
	assign accept       = item.valid && item.ready;
	assign push_valid   = (state_q == F_PUSH);
	assign kb_eff       = (cfg.data == '0) ? KB_BITS'(1) : cfg.data;
	assign divisor_next = DIV_BITS'(kb_eff * BASES_PER_KB);

	always_comb begin
		push_cmd.op    = OP_NONE;
		push_cmd.a_bin = BIN_BITS'(row_q);
		push_cmd.b_bin = BIN_BITS'(col_q);
		unique case (action_q)
			ACT_ADD: begin
				push_cmd.a_bin = quo_a_q[BIN_BITS-1:0];
				push_cmd.b_bin = quo_b_q[BIN_BITS-1:0];
				if (quo_a_q > POS_BITS'(BINS - 1) || quo_b_q > POS_BITS'(BINS - 1)) begin
					push_cmd.op = OP_DROP;
				end else if (quo_a_q == quo_b_q) begin
					push_cmd.op = OP_SAME;
				end else begin
					push_cmd.op = OP_COUNT;
				end
			end
			ACT_READ: begin
				if (32'(row_q) >= 32'(BINS) || 32'(col_q) >= 32'(BINS)) begin
					push_cmd.op = OP_DROP;
				end else begin
					push_cmd.op = OP_READ;
				end
			end
			ACT_CLEAR: begin
				push_cmd.op = OP_CLEAR;
			end
			default: begin
				push_cmd.op = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			divisor_q <= DIV_BITS'(BASES_PER_KB);
			step_q    <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				divisor_q <= divisor_next;
			end
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (item.action == ACT_ADD) begin
							state_q <= F_DIV;
							step_q  <= STEP_BITS'(POS_BITS - 1);
						end else begin
							state_q <= F_PUSH;
						end
					end
				end
				F_DIV: begin
					step_q <= step_q - STEP_BITS'(1);
					if (step_q == '0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= item.action;
			row_q    <= item.read_row;
			col_q    <= item.read_column;
			rem_a_q  <= '0;
			quo_a_q  <= item.first_position;
			rem_b_q  <= '0;
			quo_b_q  <= item.second_position;
		end else if (state_q == F_DIV) begin
			{rem_a_q, quo_a_q} <= div_step(rem_a_q, quo_a_q, divisor_q);
			{rem_b_q, quo_b_q} <= div_step(rem_b_q, quo_b_q, divisor_q);
		end
	end

endmodule
`default_nettype wire

/* sv/bpcm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcm_queue: command queue between front end and back end
// Small register FIFO so each side can stall on its own.
// ----------------------------------------------------------------------------
module bpcm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  bpcm_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output bpcm_pkg::cmd_t pop_cmd
);
	import bpcm_pkg::*;

	cmd_t                 entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] fill_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (fill_q != QCNT_BITS'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_BITS'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + QCNT_BITS'(1);
				2'b01:   fill_q <= fill_q - QCNT_BITS'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

/* sv/bpcm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcm_back: count store and result stage
// Executes commands against the count memory: two saturating read-modify-
// writes per counted pair, cell reads, clearing sweeps and the extent.
// ----------------------------------------------------------------------------
module bpcm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  bpcm_pkg::cmd_t pop_cmd,
	bpcm_result_if.source  result,
	output logic           clearing
);
	import bpcm_pkg::*;

	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_RDA  = 7'b0000010,
		B_WRA  = 7'b0000100,
		B_WRB  = 7'b0001000,
		B_RDC  = 7'b0010000,
		B_CLR  = 7'b0100000,
		B_OUT  = 7'b1000000
	} back_state_t;

	logic [COUNT_BITS-1:0]   count_store_q [MEM_DEPTH];
	logic [COUNT_BITS-1:0]   rd_data_q;
	back_state_t             state_q;
	cmd_t                    cmd_q;
	logic [EXT_BITS-1:0]     extent_q;
	logic [ADDR_BITS-1:0]    clr_addr_q;
	logic                    clr_reply_q;
	logic                    res_valid_q;
	logic [CELL_BITS-1:0]    res_count_q;
	logic [EXT_OUT_BITS-1:0] res_bins_q;
	logic [STATUS_BITS-1:0]  res_status_q;

	logic [ADDR_BITS-1:0]    addr_ab;
	logic [ADDR_BITS-1:0]    addr_ba;
	logic [ADDR_BITS-1:0]    rd_addr;
	logic [ADDR_BITS-1:0]    wr_addr;
	logic [COUNT_BITS-1:0]   wr_data;
	logic [COUNT_BITS-1:0]   sat_count;
	logic                    we;
	logic [BIN_BITS-1:0]     hi_bin;
	logic [EXT_BITS-1:0]     hi_ext;
	logic                    out_free;
	logic [STATUS_BITS-1:0]  status_next;

	assign addr_ab   = {cmd_q.a_bin, cmd_q.b_bin};
	assign addr_ba   = {cmd_q.b_bin, cmd_q.a_bin};
	assign rd_addr   = (state_q == B_WRA) ? addr_ba : addr_ab;
	assign sat_count = (&rd_data_q) ? rd_data_q : rd_data_q + COUNT_BITS'(1);
	assign hi_bin    = (pop_cmd.a_bin > pop_cmd.b_bin) ? pop_cmd.a_bin : pop_cmd.b_bin;
	assign hi_ext    = {1'b0, hi_bin} + EXT_BITS'(1);
	assign pop_ready = (state_q == B_IDLE);
	assign clearing  = (state_q == B_CLR);
	assign out_free  = !res_valid_q || result.ready;

	assign result.valid       = res_valid_q;
	assign result.cell_count  = res_count_q;
	assign result.bins_in_use = res_bins_q;
	assign result.status      = res_status_q;

	always_comb begin
		we      = 1'b0;
		wr_addr = addr_ab;
		wr_data = sat_count;
		unique case (state_q)
			B_WRA: begin
				we = 1'b1;
			end
			B_WRB: begin
				we      = 1'b1;
				wr_addr = addr_ba;
			end
			B_CLR: begin
				we      = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = '0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_comb begin
		unique case (cmd_q.op)
			OP_SAME: status_next = ST_SAME;
			OP_DROP: status_next = ST_RANGE;
			default: status_next = ST_DONE;
		endcase
	end

	// count store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			count_store_q[wr_addr] <= wr_data;
		end
		rd_data_q <= count_store_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cmd_q <= pop_cmd;
		end
		if (state_q == B_OUT && out_free) begin
			res_count_q  <= (cmd_q.op == OP_READ) ? CELL_BITS'(rd_data_q) : '0;
			res_bins_q   <= EXT_OUT_BITS'(extent_q);
			res_status_q <= status_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLR;
			extent_q    <= '0;
			clr_addr_q  <= '0;
			clr_reply_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == B_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						unique case (pop_cmd.op)
							OP_COUNT: begin
								if (hi_ext > extent_q) begin
									extent_q <= hi_ext;
								end
								state_q <= B_RDA;
							end
							OP_SAME: begin
								if (hi_ext > extent_q) begin
									extent_q <= hi_ext;
								end
								state_q <= B_OUT;
							end
							OP_READ: begin
								state_q <= B_RDC;
							end
							OP_CLEAR: begin
								extent_q    <= '0;
								clr_addr_q  <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= B_CLR;
							end
							default: begin
								state_q <= B_OUT;
							end
						endcase
					end
				end
				B_RDA: begin
					state_q <= B_WRA;
				end
				B_WRA: begin
					state_q <= B_WRB;
				end
				B_WRB: begin
					state_q <= B_OUT;
				end
				B_RDC: begin
					state_q <= B_OUT;
				end
				B_CLR: begin
					clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
					if (&clr_addr_q) begin
						state_q <= clr_reply_q ? B_OUT : B_IDLE;
					end
				end
				B_OUT: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/binned_pair_contact_matrix.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binned_pair_contact_matrix: symmetric binned contact-count matrix
// Item channel "item" carries an action (add pair, read cell, clear) with two
// positions and a cell address; every item gives exactly one transfer on
// "result" with the cell count, the bins in use and a status code.
// The bin width in kilobases is written on "cfg" while the block is idle.
// An add runs two side-by-side radix-2 dividers that find both bins,
// then two saturating read-modify-writes on the single write port of
// the count memory. The front end takes the next item once it has pushed
// the command of the last one to the queue and no clear is running.
// A clear sweeps the whole count memory, one cell a cycle.
// After reset the same sweep runs, and no item is taken
// until it ends; configuration writes are taken at all times.
// A two-entry command queue lets the dividers start on the next pair while
// the memory side is busy, and a result register holds one finished result
// while the receiver stalls, so intake goes on until both are full.
// ----------------------------------------------------------------------------
module binned_pair_contact_matrix (
	input  logic          clk,
	input  logic          arst_n,
	bpcm_item_if.sink     item,
	bpcm_result_if.source result,
	bpcm_cfg_if.sink      cfg
);
	import bpcm_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;
	logic clearing;

	bpcm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg        (cfg),
		.clearing   (clearing),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	bpcm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	bpcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.result    (result),
		.clearing  (clearing)
	);

endmodule
`default_nettype wire

/* sv/bpcm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcm_checker: port-level checks of the binned pair contact matrix
// Watches the result channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
module bpcm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic [bpcm_pkg::CELL_BITS-1:0]    res_count,
	input logic [bpcm_pkg::EXT_OUT_BITS-1:0] res_bins,
	input logic [bpcm_pkg::STATUS_BITS-1:0]  res_status
);
	import bpcm_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_count)
			&& $stable(res_bins) && $stable(res_status))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_status == ST_DONE || res_status == ST_SAME
			|| res_status == ST_RANGE))
		else $error("unknown status code");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_DONE |-> res_count == '0)
		else $error("nonzero count on same-bin or out-of-range result");

endmodule

bind binned_pair_contact_matrix bpcm_checker u_bpcm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_count  (result.cell_count),
	.res_bins   (result.bins_in_use),
	.res_status (result.status)
);
`default_nettype wire
